@@ src/cphc_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cphc_pkg - shared types and constants of the calibrated heater controller
// Widths, fixed-point coefficients, register codes, control and status types.
// ----------------------------------------------------------------------------
package cphc_pkg;

	localparam int SAMPLE_BITS    = 12;
	localparam int COEF_FRAC_BITS = 8;

	localparam int ADC_W    = 12;
	localparam int TEMP_W   = 10;
	localparam int TARGET_W = 9;
	localparam int DUTY_W   = 12;

	localparam int X_W     = (SAMPLE_BITS > ADC_W) ? SAMPLE_BITS : ADC_W;
	localparam int DX_W    = X_W + 1;
	localparam int DY_W    = TEMP_W + 1;
	localparam int PROD_W  = DX_W + DY_W;
	localparam int MAG_W   = X_W + TEMP_W;
	localparam int CNT_W   = $clog2(MAG_W + 1);
	localparam int TS_W    = MAG_W + 2;
	localparam int ERR_W   = TEMP_W + 1;
	localparam int COEF_W  = COEF_FRAC_BITS + 4;
	localparam int MPROD_W = COEF_W + ERR_W;
	localparam int ACC_W   = 32;
	localparam int SUM_W   = ((MPROD_W > ACC_W) ? MPROD_W : ACC_W) + 2;
	localparam int WHOLE_W = ACC_W - COEF_FRAC_BITS;

	localparam int TEMP_MAX = (1 << TEMP_W) - 1;

	localparam int COEF_ONE = 1 << COEF_FRAC_BITS;
	localparam logic signed [COEF_W-1:0] COEF_A0 = COEF_W'((62 * COEF_ONE + 5) / 10);
	localparam logic signed [COEF_W-1:0] COEF_A1 = COEF_W'(-((54 * COEF_ONE + 5) / 10));
	localparam logic signed [COEF_W-1:0] COEF_A2 = COEF_W'((2 * COEF_ONE + 5) / 10);

	localparam int CFG_DATA_W = 32;
	localparam int CFG_ADDR_W = 5;
	localparam int REG_IDX_W  = 3;

	localparam logic [TEMP_W-1:0] RST_CAL_TEMP_ZERO  = TEMP_W'(25);
	localparam logic [ADC_W-1:0]  RST_CAL_ADC_ONE    = ADC_W'(1212);
	localparam logic [TEMP_W-1:0] RST_CAL_TEMP_ONE   = TEMP_W'(216);
	localparam logic [ADC_W-1:0]  RST_CAL_ADC_TWO    = ADC_W'(1696);
	localparam logic [TEMP_W-1:0] RST_CAL_TEMP_TWO   = TEMP_W'(308);
	localparam logic [ADC_W-1:0]  RST_CAL_ADC_THREE  = ADC_W'(2181);
	localparam logic [TEMP_W-1:0] RST_CAL_TEMP_THREE = TEMP_W'(390);
	localparam logic [DUTY_W-1:0] RST_DUTY_LIMIT     = DUTY_W'(1999);

	typedef enum logic [REG_IDX_W-1:0] {
		REG_CAL_TEMP_ZERO,
		REG_CAL_ADC_ONE,
		REG_CAL_TEMP_ONE,
		REG_CAL_ADC_TWO,
		REG_CAL_TEMP_TWO,
		REG_CAL_ADC_THREE,
		REG_CAL_TEMP_THREE,
		REG_DUTY_LIMIT
	} reg_idx_t;

	typedef struct packed {
		logic [TEMP_W-1:0] cal_temp_zero;
		logic [ADC_W-1:0]  cal_adc_one;
		logic [TEMP_W-1:0] cal_temp_one;
		logic [ADC_W-1:0]  cal_adc_two;
		logic [TEMP_W-1:0] cal_temp_two;
		logic [ADC_W-1:0]  cal_adc_three;
		logic [TEMP_W-1:0] cal_temp_three;
		logic [DUTY_W-1:0] duty_limit;
	} cphc_cfg_t;

	typedef enum logic [1:0] {
		MAC_ERR0,
		MAC_ERR1,
		MAC_ERR2
	} mac_sel_t;

	typedef struct packed {
		logic     load;
		logic     prod;
		logic     div_step;
		logic     temp;
		logic     mac;
		mac_sel_t mac_sel;
		logic     commit;
	} cphc_cmd_t;

	typedef struct packed {
		logic div_done;
	} cphc_status_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PROD,
		ST_DIV,
		ST_MAC0,
		ST_MAC1,
		ST_MAC2,
		ST_COMMIT
	} state_t;

endpackage
`default_nettype wire

@@ src/cphc_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cphc_if - request channels of the calibrated heater controller
// Sample request channel and result channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface cphc_in_if;
	logic                             valid;
	logic                             ready;
	logic [cphc_pkg::SAMPLE_BITS-1:0] sensor_sample;
	logic [cphc_pkg::TARGET_W-1:0]    target_temp;

	modport source (output valid, output sensor_sample, output target_temp, input ready);
	modport sink   (input valid, input sensor_sample, input target_temp, output ready);
endinterface

interface cphc_out_if;
	logic                          valid;
	logic                          ready;
	logic [cphc_pkg::TEMP_W-1:0]   measured_temp;
	logic [cphc_pkg::DUTY_W-1:0]   heater_duty;

	modport source (output valid, output measured_temp, output heater_duty, input ready);
	modport sink   (input valid, input measured_temp, input heater_duty, output ready);
endinterface
`default_nettype wire

@@ src/calibrated_pid_heater_control.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// calibrated_pid_heater_control - calibrated sensor to heater duty controller
// One request per control period: raw sample and target in, temperature and
// new duty out, through an incremental PID with saturating accumulator.
// ----------------------------------------------------------------------------
// usage
//   sample_in  request channel: sensor_sample, target_temp (valid/ready)
//   result_out result channel: measured_temp, heater_duty (valid/ready)
//   apb port   eight calibration and limit registers at byte address 4*i
// timing
//   one request is worked at a time; sample_in.ready is high only while
//   the sequencer is idle
//   a request runs from accept to result valid through segment select
//   in the accept cycle, product, 22 steps of the one-bit restoring divider
//   and a temperature step, three passes through the shared pid multiplier
//   and a commit
// stall
//   the result register holds while result_out.ready is low; the next
//   request is still accepted and worked, and its commit waits for the
//   result register to free up
// reset
//   registers go to their calibration defaults, accumulator and error
//   history to zero, no result is pending
// ----------------------------------------------------------------------------
module calibrated_pid_heater_control (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [cphc_pkg::CFG_ADDR_W-1:0] paddr,
	input  logic [cphc_pkg::CFG_DATA_W-1:0] pwdata,
	output logic [cphc_pkg::CFG_DATA_W-1:0] prdata,
	output logic                            pready,
	cphc_in_if.sink                         sample_in,
	cphc_out_if.source                      result_out
);

	cphc_pkg::cphc_cfg_t    cfg;
	cphc_pkg::cphc_cmd_t    cmd;
	cphc_pkg::cphc_status_t status;

	cphc_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	cphc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (sample_in.valid),
		.in_ready  (sample_in.ready),
		.out_valid (result_out.valid),
		.out_ready (result_out.ready),
		.cmd       (cmd),
		.status    (status)
	);

	cphc_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.status        (status),
		.cfg           (cfg),
		.sensor_sample (sample_in.sensor_sample),
		.target_temp   (sample_in.target_temp),
		.measured_temp (result_out.measured_temp),
		.heater_duty   (result_out.heater_duty)
	);

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(sample_in.valid && sample_in.ready) |=> !sample_in.ready)
		else $error("request accepted while a request is in work");

	a_valid_from_commit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_out.valid) |-> $past(cmd.commit))
		else $error("result valid without a commit");

	a_commit_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> (!result_out.valid || result_out.ready))
		else $error("commit overwrote a pending result");

	a_single_command: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.load, cmd.prod, cmd.div_step, cmd.temp, cmd.mac, cmd.commit}))
		else $error("more than one datapath command at once");

endmodule
`default_nettype wire

@@ src/cphc_regs.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cphc_regs - configuration register file
// APB-style write and read access to calibration points and duty limit.
// ----------------------------------------------------------------------------
module cphc_regs (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [cphc_pkg::CFG_ADDR_W-1:0] paddr,
	input  logic [cphc_pkg::CFG_DATA_W-1:0] pwdata,
	output logic [cphc_pkg::CFG_DATA_W-1:0] prdata,
	output logic                            pready,
	output cphc_pkg::cphc_cfg_t             cfg
);

	cphc_pkg::cphc_cfg_t cfg_q;
	cphc_pkg::reg_idx_t  idx;
	logic                wr_en;

	assign idx    = cphc_pkg::reg_idx_t'(paddr[cphc_pkg::CFG_ADDR_W-1:2]);
	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.cal_temp_zero  <= cphc_pkg::RST_CAL_TEMP_ZERO;
			cfg_q.cal_adc_one    <= cphc_pkg::RST_CAL_ADC_ONE;
			cfg_q.cal_temp_one   <= cphc_pkg::RST_CAL_TEMP_ONE;
			cfg_q.cal_adc_two    <= cphc_pkg::RST_CAL_ADC_TWO;
			cfg_q.cal_temp_two   <= cphc_pkg::RST_CAL_TEMP_TWO;
			cfg_q.cal_adc_three  <= cphc_pkg::RST_CAL_ADC_THREE;
			cfg_q.cal_temp_three <= cphc_pkg::RST_CAL_TEMP_THREE;
			cfg_q.duty_limit     <= cphc_pkg::RST_DUTY_LIMIT;
		end else if (wr_en) begin
			unique case (idx)
				cphc_pkg::REG_CAL_TEMP_ZERO:  cfg_q.cal_temp_zero  <= pwdata[cphc_pkg::TEMP_W-1:0];
				cphc_pkg::REG_CAL_ADC_ONE:    cfg_q.cal_adc_one    <= pwdata[cphc_pkg::ADC_W-1:0];
				cphc_pkg::REG_CAL_TEMP_ONE:   cfg_q.cal_temp_one   <= pwdata[cphc_pkg::TEMP_W-1:0];
				cphc_pkg::REG_CAL_ADC_TWO:    cfg_q.cal_adc_two    <= pwdata[cphc_pkg::ADC_W-1:0];
				cphc_pkg::REG_CAL_TEMP_TWO:   cfg_q.cal_temp_two   <= pwdata[cphc_pkg::TEMP_W-1:0];
				cphc_pkg::REG_CAL_ADC_THREE:  cfg_q.cal_adc_three  <= pwdata[cphc_pkg::ADC_W-1:0];
				cphc_pkg::REG_CAL_TEMP_THREE: cfg_q.cal_temp_three <= pwdata[cphc_pkg::TEMP_W-1:0];
				cphc_pkg::REG_DUTY_LIMIT:     cfg_q.duty_limit     <= pwdata[cphc_pkg::DUTY_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			cphc_pkg::REG_CAL_TEMP_ZERO:  prdata = cphc_pkg::CFG_DATA_W'(cfg_q.cal_temp_zero);
			cphc_pkg::REG_CAL_ADC_ONE:    prdata = cphc_pkg::CFG_DATA_W'(cfg_q.cal_adc_one);
			cphc_pkg::REG_CAL_TEMP_ONE:   prdata = cphc_pkg::CFG_DATA_W'(cfg_q.cal_temp_one);
			cphc_pkg::REG_CAL_ADC_TWO:    prdata = cphc_pkg::CFG_DATA_W'(cfg_q.cal_adc_two);
			cphc_pkg::REG_CAL_TEMP_TWO:   prdata = cphc_pkg::CFG_DATA_W'(cfg_q.cal_temp_two);
			cphc_pkg::REG_CAL_ADC_THREE:  prdata = cphc_pkg::CFG_DATA_W'(cfg_q.cal_adc_three);
			cphc_pkg::REG_CAL_TEMP_THREE: prdata = cphc_pkg::CFG_DATA_W'(cfg_q.cal_temp_three);
			cphc_pkg::REG_DUTY_LIMIT:     prdata = cphc_pkg::CFG_DATA_W'(cfg_q.duty_limit);
			default:                      prdata = '0;
		endcase
	end

endmodule
`default_nettype wire

@@ src/cphc_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cphc_ctrl - sequencer of the calibrated heater controller
// Steps the datapath through product, division, PID terms and commit.
// ----------------------------------------------------------------------------
module cphc_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	output logic                   out_valid,
	input  logic                   out_ready,
	output cphc_pkg::cphc_cmd_t    cmd,
	input  cphc_pkg::cphc_status_t status
);

	cphc_pkg::state_t state_q, state_d;
	logic             out_valid_q, out_valid_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= cphc_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			out_valid_q <= out_valid_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			cphc_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = cphc_pkg::ST_PROD;
				end
			end
			cphc_pkg::ST_PROD: begin
				cmd.prod = 1'b1;
				state_d  = cphc_pkg::ST_DIV;
			end
			cphc_pkg::ST_DIV: begin
				if (status.div_done) begin
					cmd.temp = 1'b1;
					state_d  = cphc_pkg::ST_MAC0;
				end else begin
					cmd.div_step = 1'b1;
				end
			end
			cphc_pkg::ST_MAC0: begin
				cmd.mac     = 1'b1;
				cmd.mac_sel = cphc_pkg::MAC_ERR0;
				state_d     = cphc_pkg::ST_MAC1;
			end
			cphc_pkg::ST_MAC1: begin
				cmd.mac     = 1'b1;
				cmd.mac_sel = cphc_pkg::MAC_ERR1;
				state_d     = cphc_pkg::ST_MAC2;
			end
			cphc_pkg::ST_MAC2: begin
				cmd.mac     = 1'b1;
				cmd.mac_sel = cphc_pkg::MAC_ERR2;
				state_d     = cphc_pkg::ST_COMMIT;
			end
			cphc_pkg::ST_COMMIT: begin
				if (!out_valid_q || out_ready) begin
					cmd.commit = 1'b1;
					state_d    = cphc_pkg::ST_IDLE;
				end
			end
			default: state_d = cphc_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		if (cmd.commit) begin
			out_valid_d = 1'b1;
		end else if (out_ready) begin
			out_valid_d = 1'b0;
		end else begin
			out_valid_d = out_valid_q;
		end
	end

	assign out_valid = out_valid_q;

endmodule
`default_nettype wire

@@ src/cphc_dp.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cphc_dp - datapath of the calibrated heater controller
// Segment select, interpolation product, restoring divider, PID multiply-
// accumulate with saturation, duty clamp and result registers.
// ----------------------------------------------------------------------------
module cphc_dp (
	input  logic                             clk,
	input  logic                             arst_n,
	input  cphc_pkg::cphc_cmd_t              cmd,
	output cphc_pkg::cphc_status_t           status,
	input  cphc_pkg::cphc_cfg_t              cfg,
	input  logic [cphc_pkg::SAMPLE_BITS-1:0] sensor_sample,
	input  logic [cphc_pkg::TARGET_W-1:0]    target_temp,
	output logic [cphc_pkg::TEMP_W-1:0]      measured_temp,
	output logic [cphc_pkg::DUTY_W-1:0]      heater_duty
);

	localparam int X_W     = cphc_pkg::X_W;
	localparam int DX_W    = cphc_pkg::DX_W;
	localparam int DY_W    = cphc_pkg::DY_W;
	localparam int PROD_W  = cphc_pkg::PROD_W;
	localparam int MAG_W   = cphc_pkg::MAG_W;
	localparam int CNT_W   = cphc_pkg::CNT_W;
	localparam int TS_W    = cphc_pkg::TS_W;
	localparam int TEMP_W  = cphc_pkg::TEMP_W;
	localparam int ERR_W   = cphc_pkg::ERR_W;
	localparam int COEF_W  = cphc_pkg::COEF_W;
	localparam int MPROD_W = cphc_pkg::MPROD_W;
	localparam int SUM_W   = cphc_pkg::SUM_W;
	localparam int ACC_W   = cphc_pkg::ACC_W;
	localparam int WHOLE_W = cphc_pkg::WHOLE_W;
	localparam int DUTY_W  = cphc_pkg::DUTY_W;

	// captured request and segment
	logic [X_W-1:0]                  x_q, in0_q, in1_q;
	logic [TEMP_W-1:0]               out0_q, out1_q;
	logic [cphc_pkg::TARGET_W-1:0]   tgt_q;

	// divider
	logic [X_W-1:0]                  rem_q, den_q;
	logic [MAG_W-1:0]                quo_q;
	logic                            neg_q, den_zero_q;
	logic [CNT_W-1:0]                cnt_q;

	// pid
	logic [TEMP_W-1:0]               temp_q;
	logic signed [ERR_W-1:0]         err_q, e1_q, e2_q;
	logic signed [SUM_W-1:0]         sum_q;
	logic signed [ACC_W-1:0]         acc_q;

	// result registers
	logic [TEMP_W-1:0]               res_temp_q;
	logic [DUTY_W-1:0]               res_duty_q;

	logic [X_W-1:0]                  x_ext, a1, a2, a3;
	logic [X_W-1:0]                  seg_in0, seg_in1;
	logic [TEMP_W-1:0]               seg_out0, seg_out1;

	logic signed [DX_W-1:0]          dx, den;
	logic signed [DY_W-1:0]          dy;
	logic signed [PROD_W-1:0]        prod, prod_abs;
	logic signed [DX_W-1:0]          den_abs;

	logic [X_W:0]                    rem_sh, rem_sub;
	logic                            fits;

	logic signed [TS_W-1:0]          qs, t_full;
	logic [TEMP_W-1:0]               temp_c;
	logic signed [ERR_W-1:0]         err_d;

	logic signed [COEF_W-1:0]        coef;
	logic signed [ERR_W-1:0]         opd;
	logic signed [MPROD_W-1:0]       mprod;
	logic signed [SUM_W-1:0]         base, sum_d;

	logic [SUM_W-ACC_W:0]            upper;
	logic signed [ACC_W-1:0]         y_sat;
	logic [WHOLE_W-1:0]              whole;
	logic [DUTY_W-1:0]               duty_d;

	// segment choice
	assign x_ext = X_W'(sensor_sample);
	assign a1    = X_W'(cfg.cal_adc_one);
	assign a2    = X_W'(cfg.cal_adc_two);
	assign a3    = X_W'(cfg.cal_adc_three);

	always_comb begin
		if (x_ext <= a1) begin
			seg_in0  = '0;
			seg_in1  = a1;
			seg_out0 = cfg.cal_temp_zero;
			seg_out1 = cfg.cal_temp_one;
		end else if (x_ext <= a2) begin
			seg_in0  = a1;
			seg_in1  = a2;
			seg_out0 = cfg.cal_temp_one;
			seg_out1 = cfg.cal_temp_two;
		end else begin
			seg_in0  = a2;
			seg_in1  = a3;
			seg_out0 = cfg.cal_temp_two;
			seg_out1 = cfg.cal_temp_three;
		end
	end

	// interpolation product and divisor
	assign dx       = $signed({1'b0, x_q}) - $signed({1'b0, in0_q});
	assign den      = $signed({1'b0, in1_q}) - $signed({1'b0, in0_q});
	assign dy       = $signed({1'b0, out1_q}) - $signed({1'b0, out0_q});
	assign prod     = dx * dy;
	assign prod_abs = prod[PROD_W-1] ? -prod : prod;
	assign den_abs  = den[DX_W-1] ? -den : den;

	// one quotient bit per step
	assign rem_sh  = {rem_q, quo_q[MAG_W-1]};
	assign fits    = rem_sh >= {1'b0, den_q};
	assign rem_sub = rem_sh - {1'b0, den_q};

	assign status.div_done = (cnt_q == CNT_W'(MAG_W));

	// signed quotient, offset and clamp
	assign qs = neg_q ? -$signed({2'b00, quo_q}) : $signed({2'b00, quo_q});

	always_comb begin
		if (den_zero_q) begin
			t_full = $signed(TS_W'(out0_q));
		end else begin
			t_full = qs + $signed(TS_W'(out0_q));
		end
		if (t_full[TS_W-1]) begin
			temp_c = '0;
		end else if (t_full > $signed(TS_W'(cphc_pkg::TEMP_MAX))) begin
			temp_c = TEMP_W'(cphc_pkg::TEMP_MAX);
		end else begin
			temp_c = t_full[TEMP_W-1:0];
		end
	end

	assign err_d = $signed(ERR_W'(tgt_q)) - $signed(ERR_W'(temp_c));

	// shared multiplier for the three pid terms
	always_comb begin
		case (cmd.mac_sel)
			cphc_pkg::MAC_ERR0: begin
				coef = cphc_pkg::COEF_A0;
				opd  = err_q;
			end
			cphc_pkg::MAC_ERR1: begin
				coef = cphc_pkg::COEF_A1;
				opd  = e1_q;
			end
			cphc_pkg::MAC_ERR2: begin
				coef = cphc_pkg::COEF_A2;
				opd  = e2_q;
			end
			default: begin
				coef = '0;
				opd  = '0;
			end
		endcase
	end

	assign mprod = coef * opd;
	assign base  = (cmd.mac_sel == cphc_pkg::MAC_ERR0) ? SUM_W'(acc_q) : sum_q;
	assign sum_d = base + SUM_W'(mprod);

	// 32-bit saturation and duty clamp
	assign upper = sum_q[SUM_W-1:ACC_W-1];

	always_comb begin
		if ((upper == '0) || (upper == '1)) begin
			y_sat = sum_q[ACC_W-1:0];
		end else if (sum_q[SUM_W-1]) begin
			y_sat = {1'b1, {(ACC_W-1){1'b0}}};
		end else begin
			y_sat = {1'b0, {(ACC_W-1){1'b1}}};
		end
	end

	assign whole = y_sat[ACC_W-1:cphc_pkg::COEF_FRAC_BITS];

	always_comb begin
		if (y_sat[ACC_W-1] || (y_sat == '0)) begin
			duty_d = '0;
		end else if (whole > WHOLE_W'(cfg.duty_limit)) begin
			duty_d = cfg.duty_limit;
		end else begin
			duty_d = whole[DUTY_W-1:0];
		end
	end

	// controller state held in the datapath
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			acc_q <= '0;
			e1_q  <= '0;
			e2_q  <= '0;
		end else begin
			if (cmd.prod) begin
				cnt_q <= '0;
			end else if (cmd.div_step) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end
			if (cmd.commit) begin
				acc_q <= y_sat;
				e2_q  <= e1_q;
				e1_q  <= err_q;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			x_q    <= x_ext;
			tgt_q  <= target_temp;
			in0_q  <= seg_in0;
			in1_q  <= seg_in1;
			out0_q <= seg_out0;
			out1_q <= seg_out1;
		end
		if (cmd.prod) begin
			rem_q      <= '0;
			quo_q      <= prod_abs[MAG_W-1:0];
			den_q      <= den_abs[X_W-1:0];
			neg_q      <= prod[PROD_W-1] ^ den[DX_W-1];
			den_zero_q <= (den == '0);
		end else if (cmd.div_step) begin
			rem_q <= fits ? rem_sub[X_W-1:0] : rem_sh[X_W-1:0];
			quo_q <= {quo_q[MAG_W-2:0], fits};
		end
		if (cmd.temp) begin
			temp_q <= temp_c;
			err_q  <= err_d;
		end
		if (cmd.mac) begin
			sum_q <= sum_d;
		end
		if (cmd.commit) begin
			res_temp_q <= temp_q;
			res_duty_q <= duty_d;
		end
	end

	assign measured_temp = res_temp_q;
	assign heater_duty   = res_duty_q;

endmodule
`default_nettype wire
